// ===== rtl/core/jtl_pkg.sv =====
// Shared types and constants of the JSON token lexer.
`timescale 1ns / 1ps

package jtl_pkg;

  localparam int OFFSET_BITS = 32;   // width of the running byte offset
  localparam int OUT_BITS    = 32;   // width of the offsets on the result channel
  localparam int BYTE_BITS   = 8;
  localparam int KIND_BITS   = 3;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  typedef logic [OFFSET_BITS-1:0] offset_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_STR   = 3'd0,
    KIND_NUM   = 3'd1,
    KIND_COLON = 3'd2,
    KIND_COMMA = 3'd3,
    KIND_OPEN  = 3'd4,
    KIND_CLOSE = 3'd5,
    KIND_END   = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [OUT_BITS-1:0] start_off;
    logic [OUT_BITS-1:0] end_off;
    logic                run_last;
  } result_t;

  // Up to two tokens produced by one byte, in emission order.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

// ===== rtl/core/jtl_if.sv =====
// Stream interfaces for the byte input channel and the token result channel.
`timescale 1ns / 1ps

interface jtl_in_if;
  logic                          valid;
  logic                          ready;
  logic [jtl_pkg::BYTE_BITS-1:0] byte_value;
  logic                          last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface jtl_out_if;
  logic                          valid;
  logic                          ready;
  logic [jtl_pkg::KIND_BITS-1:0] token_kind;
  logic [jtl_pkg::OUT_BITS-1:0]  start_offset;
  logic [jtl_pkg::OUT_BITS-1:0]  end_offset;
  logic                          run_last;

  modport source (output valid, output token_kind, output start_offset,
                  output end_offset, output run_last, input ready);
  modport sink   (input valid, input token_kind, input start_offset,
                  input end_offset, input run_last, output ready);
endinterface

// ===== rtl/core/jtl_lexer.sv =====
// Lexer state and single-pass per-byte token logic.
`timescale 1ns / 1ps

module jtl_lexer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  logic [jtl_pkg::BYTE_BITS-1:0] byte_value,
  input  logic                          last_byte,
  output jtl_pkg::push_t                push
);
  import jtl_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_WORD  = 3'd1,
    M_INT   = 3'd2,
    M_FRAC  = 3'd3,
    M_QUOTE = 3'd4,
    M_DONE  = 3'd5,
    M_PEND  = 3'd6
  } mode_t;

  localparam logic [BYTE_BITS-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_BITS-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_BITS-1:0] CH_DOT   = 8'h2E;
  localparam logic [BYTE_BITS-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_BITS-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_BITS-1:0] CH_OPEN  = 8'h7B;
  localparam logic [BYTE_BITS-1:0] CH_CLOSE = 8'h7D;

  mode_t   mode_r, mode_nxt;
  offset_t off_r, off_nxt;
  offset_t ts_r, ts_nxt;
  push_t   acc;

  // Append a token unless two are already queued for this byte.
  function automatic push_t add_res(push_t a, kind_t k, offset_t s, offset_t en);
    push_t   r;
    result_t t;
    r           = a;
    t.kind      = k;
    t.start_off = OUT_BITS'(s);
    t.end_off   = OUT_BITS'(en);
    t.run_last  = 1'b0;
    case (a.count)
      2'd0: begin
        r.res0  = t;
        r.count = 2'd1;
      end
      2'd1: begin
        r.res1  = t;
        r.count = 2'd2;
      end
      default: ;
    endcase
    return r;
  endfunction

  always_comb begin
    mode_t   m;
    offset_t ts;
    offset_t p;
    offset_t e;
    logic    taken;
    logic    is_digit;
    logic    is_letter;

    m         = mode_r;
    ts        = ts_r;
    p         = off_r;
    e         = off_r + offset_t'(1);
    taken     = 1'b0;
    acc       = '0;
    is_digit  = byte_value inside {[8'h30:8'h39]};
    is_letter = byte_value inside {[8'h41:8'h5A], [8'h61:8'h7A]};

    // Flush an end token held back from the previous text.
    if (m == M_PEND) begin
      acc = add_res(acc, KIND_END, ts, ts);
      m   = M_IDLE;
    end

    if (m == M_DONE) begin
      if (last_byte) begin
        m       = M_IDLE;
        off_nxt = '0;
      end else begin
        off_nxt = e;
      end
    end else begin
      // Extend or close the open token.
      case (m)
        M_WORD: begin
          if (is_letter) begin
            taken = 1'b1;
          end else begin
            acc = add_res(acc, KIND_STR, ts, p);
            m   = M_IDLE;
          end
        end
        M_INT: begin
          if (is_digit) begin
            taken = 1'b1;
          end else if (byte_value == CH_DOT) begin
            m     = M_FRAC;
            taken = 1'b1;
          end else begin
            acc = add_res(acc, KIND_NUM, ts, p);
            m   = M_IDLE;
          end
        end
        M_FRAC: begin
          if (is_digit) begin
            taken = 1'b1;
          end else begin
            acc = add_res(acc, KIND_NUM, ts, p);
            m   = M_IDLE;
          end
        end
        M_QUOTE: begin
          taken = 1'b1;
          if (byte_value == CH_QUOTE) begin
            acc = add_res(acc, KIND_STR, ts, e);
            m   = M_IDLE;
          end
        end
        default: m = M_IDLE;
      endcase

      // Lex the byte from idle.
      if (!taken) begin
        case (byte_value)
          CH_NUL: begin
            acc = add_res(acc, KIND_END, p, e);
            m   = M_DONE;
          end
          CH_COLON: acc = add_res(acc, KIND_COLON, p, e);
          CH_COMMA: acc = add_res(acc, KIND_COMMA, p, e);
          CH_OPEN:  acc = add_res(acc, KIND_OPEN, p, e);
          CH_CLOSE: acc = add_res(acc, KIND_CLOSE, p, e);
          CH_QUOTE: begin
            ts = p;
            m  = M_QUOTE;
          end
          default: begin
            if (byte_value == CH_MINUS || is_digit) begin
              ts = p;
              m  = M_INT;
            end else if (is_letter) begin
              ts = p;
              m  = M_WORD;
            end
          end
        endcase
      end

      if (last_byte) begin
        if (m == M_DONE) begin
          m = M_IDLE;
        end else begin
          if (m != M_IDLE) begin
            acc = add_res(acc, (m == M_INT || m == M_FRAC) ? KIND_NUM : KIND_STR,
                          ts, e);
            m   = M_IDLE;
          end
          if (acc.count != 2'd2) begin
            acc = add_res(acc, KIND_END, e, e);
          end else begin
            // No room left: hold the end token for the next byte.
            ts = e;
            m  = M_PEND;
          end
        end
        off_nxt = '0;
      end else begin
        off_nxt = e;
      end
    end

    // Mark the final token caused by this byte.
    if (acc.count == 2'd1) begin
      acc.res0.run_last = 1'b1;
    end
    if (acc.count == 2'd2) begin
      acc.res1.run_last = 1'b1;
    end

    mode_nxt = m;
    ts_nxt   = ts;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      off_r  <= '0;
      ts_r   <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      off_r  <= off_nxt;
      ts_r   <= ts_nxt;
    end
  end

  always_comb begin
    push = acc;
    if (!fire) begin
      push.count = 2'd0;
    end
  end

endmodule

// ===== rtl/core/jtl_result_fifo.sv =====
// Small result queue: takes up to two tokens a cycle, hands out one while out_chan is ready.
`timescale 1ns / 1ps

module jtl_result_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  jtl_pkg::push_t push,
  output logic           has_room,
  jtl_out_if.source      out_chan
);
  import jtl_pkg::*;

  result_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wp_r, wp_nxt;
  logic [FIFO_PTR_W-1:0]   rp_r, rp_nxt;
  logic [FIFO_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [FIFO_PTR_W-1:0]   wp_plus1;
  logic                    pop;
  result_t                 head;

  assign wp_plus1 = wp_r + FIFO_PTR_W'(1);
  assign pop      = out_chan.valid && out_chan.ready;
  // Room is judged without the pop so out_ready has no path to in_ready.
  assign has_room = cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - 2);

  assign head                  = mem_r[rp_r];
  assign out_chan.valid        = cnt_r != '0;
  assign out_chan.token_kind   = head.kind;
  assign out_chan.start_offset = head.start_off;
  assign out_chan.end_offset   = head.end_off;
  assign out_chan.run_last     = head.run_last;

  always_comb begin
    wp_nxt  = wp_r + FIFO_PTR_W'(push.count);
    rp_nxt  = pop ? rp_r + FIFO_PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wp_r] <= push.res0;
    end
    if (push.count == 2'd2) begin
      mem_r[wp_plus1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/json_token_lexer_top.sv =====
// Top level of the streaming JSON token lexer.
`timescale 1ns / 1ps

// Streaming JSON tokenizer. Send one text byte per request on in_chan, with
// last_byte set on the final byte of a text; tokens come out on out_chan as
// kind, start offset and exclusive end offset, run_last marking the final
// token a byte caused. The block takes one byte per cycle while the result
// queue has room: a byte is held in the input register, is lexed in a single
// pass and its tokens (zero, one or two) are written into a four-entry result
// queue, from whose head the first token of a byte is offered on out_chan.
// The result port moves one token per cycle while out_chan is ready, so a byte
// that yields two tokens sends them one after the other and that single port
// sets the long-run rate when tokens outnumber bytes. The input stalls only
// while the queue holds more than two tokens. Offsets wrap at 2^32. A NUL
// outside quotes ends the text early; later bytes up to the last-marked one
// are dropped. When the last byte already yields two tokens, its end token is
// held and sent first with the next byte's results.
module json_token_lexer_top (
  input  logic       clk,
  input  logic       rst_n,
  jtl_in_if.sink     in_chan,
  jtl_out_if.source  out_chan
);
  import jtl_pkg::*;

  logic                 in_v_r, in_v_nxt;
  logic [BYTE_BITS-1:0] byte_r;
  logic                 last_r;
  logic                 room;
  logic                 lex_fire;
  logic                 in_acc;
  push_t                push;

  // Lex the held byte once the queue can take two tokens.
  assign lex_fire      = in_v_r && room;
  // Take a new request when the input register is empty or drains this cycle.
  assign in_chan.ready = !in_v_r || lex_fire;
  assign in_acc        = in_chan.valid && in_chan.ready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_acc) begin
      in_v_nxt = 1'b1;
    end else if (lex_fire) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  // Payload needs no reset; load it on each accepted request.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_chan.byte_value;
      last_r <= in_chan.last_byte;
    end
  end

  jtl_lexer u_lexer (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (lex_fire),
    .byte_value (byte_r),
    .last_byte  (last_r),
    .push       (push)
  );

  jtl_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .has_room (room),
    .out_chan (out_chan)
  );

endmodule
